// ----- rtl/sbc_pkg.sv -----
// shared types and constants for the swept box collision block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

	localparam int COORD_BITS     = 20;
	localparam int SIZE_BITS      = COORD_BITS - 1;
	localparam int TIME_FRAC_BITS = 16;
	localparam int TIME_OUT_BITS  = TIME_FRAC_BITS + 1;

	// distances need two more bits than a coordinate, relative speed one more
	localparam int DIST_BITS = COORD_BITS + 2;
	localparam int VEL_BITS  = COORD_BITS + 1;
	localparam int DMAG_BITS = DIST_BITS;
	localparam int VMAG_BITS = VEL_BITS - 1 + 1;

	// quotient magnitude held until saturation: 2.0 needs TIME_FRAC_BITS+2 bits
	localparam int QSAT_BITS = TIME_FRAC_BITS + 2;
	// signed time with room for the infinity codes at +-4.0
	localparam int TIME_BITS = TIME_FRAC_BITS + 4;
	localparam int QBITS     = QSAT_BITS;

	localparam logic signed [TIME_BITS-1:0] TIME_ONE =
		TIME_BITS'(64'sd1 << TIME_FRAC_BITS);
	localparam logic signed [TIME_BITS-1:0] TIME_SAT =
		TIME_BITS'(64'sd2 << TIME_FRAC_BITS);
	localparam logic signed [TIME_BITS-1:0] TIME_POS_INF =
		TIME_BITS'(64'sd4 << TIME_FRAC_BITS);
	localparam logic signed [TIME_BITS-1:0] TIME_NEG_INF =
		TIME_BITS'(-(64'sd4 << TIME_FRAC_BITS));

	// contact side codes
	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_LEFT   = 3'd1,
		SIDE_RIGHT  = 3'd2,
		SIDE_TOP    = 3'd3,
		SIDE_BOTTOM = 3'd4
	} side_t;

	// one restoring division in flight: dividend shifted in bit by bit
	typedef struct packed {
		logic                  active; // divisor non-zero
		logic                  neg;    // quotient negative
		logic [DMAG_BITS-1:0]  num;    // |distance|, bits consumed msb first
		logic [VMAG_BITS-1:0]  den;    // |relative speed|
		logic [VMAG_BITS:0]    rem;    // partial remainder
		logic [QBITS-1:0]      quo;    // quotient bits, shifted in at the lsb
		logic                  ovf;    // quotient beyond saturation
	} div_lane_t;

	// per-item context carried beside the divider lanes
	typedef struct packed {
		logic                        bp_hit;
		logic                        dxe_pos;
		logic                        dye_pos;
	} item_ctx_t;

endpackage

`default_nettype wire

// ----- rtl/sbc_div_cell.sv -----
// one cell of the divider chain: one quotient bit for each of four lanes
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_div_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_vld,
	input  wire sbc_pkg::div_lane_t  in_lane [4],
	input  wire sbc_pkg::item_ctx_t  in_ctx,
	output logic                     out_vld,
	output sbc_pkg::div_lane_t       out_lane [4],
	output sbc_pkg::item_ctx_t       out_ctx
);
	import sbc_pkg::*;

	div_lane_t nxt [4];
	logic [VMAG_BITS:0] trial;
	logic [VMAG_BITS+1:0] diff;

	// restoring step on each lane
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nxt[i] = in_lane[i];
			trial  = {in_lane[i].rem[VMAG_BITS-1:0], in_lane[i].num[DMAG_BITS-1]};
			diff   = {1'b0, trial} - {2'b00, in_lane[i].den};
			nxt[i].num = {in_lane[i].num[DMAG_BITS-2:0], 1'b0};
			if (!diff[VMAG_BITS+1]) begin
				nxt[i].rem = diff[VMAG_BITS:0];
			end else begin
				nxt[i].rem = trial;
			end
			nxt[i].ovf = in_lane[i].ovf | in_lane[i].quo[QBITS-1];
			nxt[i].quo = {in_lane[i].quo[QBITS-2:0], ~diff[VMAG_BITS+1]};
		end
	end

	// stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_lane <= nxt;
			out_ctx  <= in_ctx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sbc_front.sv -----
// front stage: broadphase test, distances and divider lane setup
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_front (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    adv,
	input  wire logic                                    in_vld,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   mx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   my,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]    mw,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]    mh,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   mvx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   mvy,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   tx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   ty,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]    tw,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]    th,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   tvx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]   tvy,
	output logic                                         out_vld,
	output sbc_pkg::div_lane_t                           out_lane [4],
	output sbc_pkg::item_ctx_t                           out_ctx
);
	import sbc_pkg::*;

	localparam int W = COORD_BITS + 3;

	logic signed [W-1:0] emx, emy, emw, emh, emvx, emvy, etx, ety, etw, eth;
	logic signed [W-1:0] sx, sy, sw, sh, rvx, rvy;
	logic signed [W-1:0] dxe, dxx, dye, dyx;
	logic signed [W-1:0] num [4];
	logic signed [W-1:0] den [4];
	logic [W-1:0] nmag, dmag;
	logic bp;
	div_lane_t lane [4];
	item_ctx_t ctx;

	// widen all operands
	always_comb begin
		emx  = W'(mx);   emy  = W'(my);
		emw  = W'($signed({1'b0, mw})); emh = W'($signed({1'b0, mh}));
		emvx = W'(mvx);  emvy = W'(mvy);
		etx  = W'(tx);   ety  = W'(ty);
		etw  = W'($signed({1'b0, tw})); eth = W'($signed({1'b0, th}));
		rvx  = W'(mvx) - W'(tvx);
		rvy  = W'(mvy) - W'(tvy);
	end

	// broadphase with the mover swept by its own displacement
	always_comb begin
		sx = (emvx > 0) ? emx : emx + emvx;
		sy = (emvy > 0) ? emy : emy + emvy;
		sw = (emvx > 0) ? emvx + emw : emw - emvx;
		sh = (emvy > 0) ? emvy + emh : emh - emvy;
		bp = !((sx + sw < etx) || (sx > etx + etw) || (sy + sh < ety) || (sy > ety + eth));
	end

	// entry and exit distances by relative direction
	always_comb begin
		if (rvx > 0) begin
			dxe = etx - (emx + emw);
			dxx = (etx + etw) - emx;
		end else begin
			dxe = (etx + etw) - emx;
			dxx = etx - (emx + emw);
		end
		if (rvy > 0) begin
			dye = ety - (emy + emh);
			dyx = (ety + eth) - emy;
		end else begin
			dye = (ety + eth) - emy;
			dyx = ety - (emy + emh);
		end
	end

	// lane setup: magnitudes and sign of each quotient
	always_comb begin
		num[0] = dxe; num[1] = dxx; num[2] = dye; num[3] = dyx;
		den[0] = rvx; den[1] = rvx; den[2] = rvy; den[3] = rvy;
		for (int i = 0; i < 4; i++) begin
			nmag = num[i][W-1] ? -num[i] : num[i];
			dmag = den[i][W-1] ? -den[i] : den[i];
			lane[i].active = (den[i] != '0);
			lane[i].neg    = (num[i][W-1] ^ den[i][W-1]) && (num[i] != '0);
			lane[i].num    = nmag[DMAG_BITS-1:0];
			lane[i].den    = dmag[VMAG_BITS-1:0];
			lane[i].rem    = '0;
			lane[i].quo    = '0;
			lane[i].ovf    = 1'b0;
		end
		ctx.bp_hit  = bp;
		ctx.dxe_pos = (dxe > 0);
		ctx.dye_pos = (dye > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_lane <= lane;
			out_ctx  <= ctx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sbc_back.sv -----
// back stage: fractional quotient bits done, rounding, saturation and decision
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_back (
	input  wire logic                                   clk,
	input  wire logic                                   adv,
	input  wire sbc_pkg::div_lane_t                     in_lane [4],
	input  wire sbc_pkg::item_ctx_t                     in_ctx,
	output logic                                        hit,
	output logic [sbc_pkg::TIME_OUT_BITS-1:0]           entry_time,
	output logic signed [1:0]                           normal_x,
	output logic signed [1:0]                           normal_y,
	output logic [2:0]                                  contact_side
);
	import sbc_pkg::*;

	logic signed [TIME_BITS-1:0] tv [4];
	logic [QBITS:0] mag;
	logic signed [TIME_BITS-1:0] xen, xex, yen, yex, ten, tex;
	logic h;
	logic [TIME_OUT_BITS-1:0] t;
	logic signed [1:0] nx, ny;
	side_t sd;

	// floor rounding and saturation to +-2.0, infinity codes on zero speed
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag = {1'b0, in_lane[i].quo};
			if (!in_lane[i].active) begin
				tv[i] = (i % 2 == 0) ? TIME_NEG_INF : TIME_POS_INF;
			end else if (in_lane[i].ovf) begin
				tv[i] = in_lane[i].neg ? -TIME_SAT : TIME_SAT;
			end else begin
				if (in_lane[i].neg && (in_lane[i].rem != '0)) begin
					mag = mag + 1'b1;
				end
				if (mag > (QBITS + 1)'(TIME_SAT)) begin
					mag = (QBITS + 1)'(TIME_SAT);
				end
				tv[i] = in_lane[i].neg ? -TIME_BITS'(mag) : TIME_BITS'(mag);
			end
		end
	end

	// decision, contact axis and side
	always_comb begin
		xen = tv[0]; xex = tv[1]; yen = tv[2]; yex = tv[3];
		ten = (xen > yen) ? xen : yen;
		tex = (xex < yex) ? xex : yex;
		h  = in_ctx.bp_hit;
		t  = TIME_OUT_BITS'(TIME_ONE);
		nx = 2'sd0;
		ny = 2'sd0;
		sd = SIDE_NONE;
		if (h) begin
			if ((ten > tex) || (xen < 0 && yen < 0) || (xen > TIME_ONE) || (yen > TIME_ONE)) begin
				h = 1'b0;
			end else begin
				t = ten[TIME_OUT_BITS-1:0];
				if (xen > yen) begin
					if (in_ctx.dxe_pos) begin
						nx = -2'sd1; sd = SIDE_RIGHT;
					end else begin
						nx = 2'sd1;  sd = SIDE_LEFT;
					end
				end else begin
					if (in_ctx.dye_pos) begin
						ny = -2'sd1; sd = SIDE_TOP;
					end else begin
						ny = 2'sd1;  sd = SIDE_BOTTOM;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			hit          <= h;
			entry_time   <= t;
			normal_x     <= nx;
			normal_y     <= ny;
			contact_side <= sd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/swept_box_collision.sv -----
// top level of the swept box collision block: front stage, divider cell chain, back stage
// depends on sbc_pkg, sbc_front, sbc_div_cell, sbc_back
// front stage, one divider cell per quotient bit, back stage output register, in that order
// throughput: one transaction per cycle unless the output stalls; the whole chain advances together
// a stall on the output freezes the chain; stall on the input follows it
// reset clears all stage valid bits asynchronously; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module swept_box_collision (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  mover_x,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  mover_y,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]   mover_w,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]   mover_h,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  mover_vx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  mover_vy,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  target_x,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  target_y,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]   target_w,
	input  wire logic        [sbc_pkg::SIZE_BITS-1:0]   target_h,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  target_vx,
	input  wire logic signed [sbc_pkg::COORD_BITS-1:0]  target_vy,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        hit,
	output logic [sbc_pkg::TIME_OUT_BITS-1:0]           entry_time,
	output logic signed [1:0]                           normal_x,
	output logic signed [1:0]                           normal_y,
	output logic [2:0]                                  contact_side
);
	import sbc_pkg::*;

	// quotient bits: all integer bits of the dividend plus the fraction bits
	localparam int NCELL = DMAG_BITS + TIME_FRAC_BITS;

	logic adv;
	logic vld [NCELL+1];
	div_lane_t lanes [NCELL+1][4];
	item_ctx_t ctxs [NCELL+1];
	div_lane_t ext_lane [NCELL+1][4];
	logic out_vld_q;

	// chain moves whenever the output slot is free or being taken
	assign adv       = !out_vld_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_vld_q;

	sbc_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(in_valid),
		.mx(mover_x), .my(mover_y), .mw(mover_w), .mh(mover_h),
		.mvx(mover_vx), .mvy(mover_vy), .tx(target_x), .ty(target_y),
		.tw(target_w), .th(target_h), .tvx(target_vx), .tvy(target_vy),
		.out_vld(vld[0]), .out_lane(lanes[0]), .out_ctx(ctxs[0])
	);

	// after the dividend bits run out, zeros shift in for the fraction bits
	always_comb begin
		ext_lane = lanes;
	end

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		sbc_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.in_vld(vld[c]), .in_lane(ext_lane[c]), .in_ctx(ctxs[c]),
			.out_vld(vld[c+1]), .out_lane(lanes[c+1]), .out_ctx(ctxs[c+1])
		);
	end

	sbc_back u_back (
		.clk(clk), .adv(adv), .in_lane(lanes[NCELL]), .in_ctx(ctxs[NCELL]),
		.hit(hit), .entry_time(entry_time), .normal_x(normal_x),
		.normal_y(normal_y), .contact_side(contact_side)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld[NCELL];
		end
	end

endmodule

`default_nettype wire
